// ===== hdl/asv_pkg.sv =====
// shared constants and helper functions for the arrival steering block
package asv_pkg;

    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_X      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_Y      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_DISTANCE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED     = 2'd3;

    // clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DATA_W+1:0] v);
        logic signed [DATA_W+1:0] hi;
        logic signed [DATA_W+1:0] lo;
        hi = (DATA_W+2)'(34'sh07FFFFFFF);
        lo = -(DATA_W+2)'(34'sh080000000);
        if (v > hi) begin
            sat32 = {1'b0, {(DATA_W-1){1'b1}}};
        end
        else if (v < lo) begin
            sat32 = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else begin
            sat32 = v[DATA_W-1:0];
        end
    endfunction

    // magnitude of a signed 32-bit value, exact for the most negative code
    function automatic logic [DATA_W-1:0] abs32(input logic signed [DATA_W-1:0] v);
        abs32 = v[DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

// ===== hdl/asv_isqrt.sv =====
// pipelined floor square root, one result bit per stage
module asv_isqrt #(
    parameter int OW = 32,
    parameter int SW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [2*OW-1:0] rad,
    input  logic [SW-1:0]   side_in,
    output logic            out_valid,
    output logic [OW-1:0]   root,
    output logic [SW-1:0]   side_out
);
    logic            valid_reg [OW];
    logic [OW+1:0]   rem_reg   [OW];
    logic [OW-1:0]   root_reg  [OW];
    logic [2*OW-1:0] rad_reg   [OW];
    logic [SW-1:0]   side_reg  [OW];

    for (genvar i = 0; i < OW; i++) begin : g_stage
        logic            pv;
        logic [OW+1:0]   prem;
        logic [OW-1:0]   proot;
        logic [2*OW-1:0] prad;
        logic [SW-1:0]   pside;
        logic [OW+3:0]   rem_sh;
        logic [OW+3:0]   trial;
        logic [OW+3:0]   rem_dif;
        logic            ge;

        if (i == 0) begin : g_first
            assign pv    = in_valid;
            assign prem  = '0;
            assign proot = '0;
            assign prad  = rad;
            assign pside = side_in;
        end
        else begin : g_next
            assign pv    = valid_reg[i-1];
            assign prem  = rem_reg[i-1];
            assign proot = root_reg[i-1];
            assign prad  = rad_reg[i-1];
            assign pside = side_reg[i-1];
        end

        assign rem_sh  = {prem, prad[2*OW-1 -: 2]};
        assign trial   = {2'b00, proot, 2'b01};
        assign rem_dif = rem_sh - trial;
        assign ge      = rem_sh >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= pv;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= ge ? rem_dif[OW+1:0] : rem_sh[OW+1:0];
                root_reg[i] <= {proot[OW-2:0], ge};
                rad_reg[i]  <= {prad[2*OW-3:0], 2'b00};
                side_reg[i] <= pside;
            end
        end
    end

    assign out_valid = valid_reg[OW-1];
    assign root      = root_reg[OW-1];
    assign side_out  = side_reg[OW-1];

endmodule

// ===== hdl/asv_div.sv =====
// pipelined restoring divider, one quotient bit per stage, quotient known to fit DW bits
module asv_div #(
    parameter int DW = 32,
    parameter int SW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [2*DW-1:0] dividend,
    input  logic [DW-1:0]   divisor,
    input  logic [SW-1:0]   side_in,
    output logic            out_valid,
    output logic [DW-1:0]   quotient,
    output logic [SW-1:0]   side_out
);
    logic          valid_reg [DW];
    logic [DW-1:0] rem_reg   [DW];
    logic [DW-1:0] lo_reg    [DW];
    logic [DW-1:0] dvs_reg   [DW];
    logic [SW-1:0] side_reg  [DW];

    for (genvar i = 0; i < DW; i++) begin : g_stage
        logic          pv;
        logic [DW-1:0] prem;
        logic [DW-1:0] plo;
        logic [DW-1:0] pdvs;
        logic [SW-1:0] pside;
        logic [DW:0]   rem2;
        logic [DW:0]   dif;
        logic          ge;

        if (i == 0) begin : g_first
            assign pv    = in_valid;
            assign prem  = dividend[2*DW-1:DW];
            assign plo   = dividend[DW-1:0];
            assign pdvs  = divisor;
            assign pside = side_in;
        end
        else begin : g_next
            assign pv    = valid_reg[i-1];
            assign prem  = rem_reg[i-1];
            assign plo   = lo_reg[i-1];
            assign pdvs  = dvs_reg[i-1];
            assign pside = side_reg[i-1];
        end

        // low dividend bits shift out the top while quotient bits shift in
        assign rem2 = {prem, plo[DW-1]};
        assign dif  = rem2 - {1'b0, pdvs};
        assign ge   = rem2 >= {1'b0, pdvs};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= pv;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= ge ? dif[DW-1:0] : rem2[DW-1:0];
                lo_reg[i]   <= {plo[DW-2:0], ge};
                dvs_reg[i]  <= pdvs;
                side_reg[i] <= pside;
            end
        end
    end

    assign out_valid = valid_reg[DW-1];
    assign quotient  = lo_reg[DW-1];
    assign side_out  = side_reg[DW-1];

endmodule

// ===== hdl/arrival_steering_vector.sv =====
// top level of the arrival steering pipeline
//
// channel   direction  handshake              payload
// in        sink       in_valid / in_stall    pos_x, pos_y, vel_x, vel_y
// out       source     out_valid / out_stall  steer_x, steer_y
// cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one transaction enters per cycle while in_stall is low; the pipe holds the
// two 32-stage square roots and the three 32-stage divider rows
// rst_n clears every stage valid bit and loads the register reset values
// a stalled output freezes the whole pipeline, so nothing is lost or repeated
// cfg_ready is always high; registers are to be written only while the pipe is empty (the user's duty, not enforced)
module arrival_steering_vector #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [asv_pkg::DATA_W-1:0]      pos_x,
    input  logic signed [asv_pkg::DATA_W-1:0]      pos_y,
    input  logic signed [asv_pkg::DATA_W-1:0]      vel_x,
    input  logic signed [asv_pkg::DATA_W-1:0]      vel_y,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [asv_pkg::DATA_W-1:0]      steer_x,
    output logic signed [asv_pkg::DATA_W-1:0]      steer_y,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [asv_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [asv_pkg::DATA_W-1:0]             cfg_data
);
    import asv_pkg::*;

    localparam logic [DATA_W-2:0] ONE_FIX = (DATA_W-1)'(64'd1 << FRAC_BITS);

    // config registers
    logic signed [DATA_W-1:0] target_x_reg;
    logic signed [DATA_W-1:0] target_y_reg;
    logic [DATA_W-2:0]        slow_reg;
    logic [DATA_W-2:0]        ms_reg;

    // whole pipe advances unless the output holds a stalled result
    logic en;
    logic out_valid_reg;
    assign en        = !out_valid_reg || !out_stall;
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_x_reg <= '0;
            target_y_reg <= '0;
            slow_reg     <= ONE_FIX;
            ms_reg       <= ONE_FIX;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TARGET_X:      target_x_reg <= cfg_data;
                CFG_TARGET_Y:      target_y_reg <= cfg_data;
                CFG_SLOW_DISTANCE: slow_reg     <= cfg_data[DATA_W-2:0];
                CFG_MAX_SPEED:     ms_reg       <= cfg_data[DATA_W-2:0];
                default:           ;
            endcase
        end
    end

    // stage a: saturated offset to target
    logic                     a_valid_reg;
    logic signed [DATA_W-1:0] a_dx_reg, a_dy_reg, a_vx_reg, a_vy_reg;
    logic signed [DATA_W+1:0] a_dx_wide, a_dy_wide;
    assign a_dx_wide = (DATA_W+2)'(target_x_reg) - (DATA_W+2)'(pos_x);
    assign a_dy_wide = (DATA_W+2)'(target_y_reg) - (DATA_W+2)'(pos_y);

    // stage b: squares
    logic                     b_valid_reg;
    logic [2*DATA_W-1:0]      b_sqx_reg, b_sqy_reg;
    logic signed [DATA_W-1:0] b_dx_reg, b_dy_reg, b_vx_reg, b_vy_reg;

    // stage c: sum of squares
    logic                     c_valid_reg;
    logic [2*DATA_W-1:0]      c_sum_reg;
    logic signed [DATA_W-1:0] c_dx_reg, c_dy_reg, c_vx_reg, c_vy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_dx_reg  <= sat32(a_dx_wide);
            a_dy_reg  <= sat32(a_dy_wide);
            a_vx_reg  <= vel_x;
            a_vy_reg  <= vel_y;
            b_sqx_reg <= (2*DATA_W)'(abs32(a_dx_reg)) * (2*DATA_W)'(abs32(a_dx_reg));
            b_sqy_reg <= (2*DATA_W)'(abs32(a_dy_reg)) * (2*DATA_W)'(abs32(a_dy_reg));
            b_dx_reg  <= a_dx_reg;
            b_dy_reg  <= a_dy_reg;
            b_vx_reg  <= a_vx_reg;
            b_vy_reg  <= a_vy_reg;
            c_sum_reg <= b_sqx_reg + b_sqy_reg;
            c_dx_reg  <= b_dx_reg;
            c_dy_reg  <= b_dy_reg;
            c_vx_reg  <= b_vx_reg;
            c_vy_reg  <= b_vy_reg;
        end
    end

    // distance to target
    localparam int SIDE1_W = 4*DATA_W;
    logic                     q1_valid;
    logic [DATA_W-1:0]        q1_dist;
    logic [SIDE1_W-1:0]       q1_side;
    logic signed [DATA_W-1:0] q1_dx, q1_dy, q1_vx, q1_vy;

    asv_isqrt #(.OW(DATA_W), .SW(SIDE1_W)) u_dist_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (c_valid_reg),
        .rad      (c_sum_reg),
        .side_in  ({c_dx_reg, c_dy_reg, c_vx_reg, c_vy_reg}),
        .out_valid(q1_valid),
        .root     (q1_dist),
        .side_out (q1_side)
    );
    assign {q1_dx, q1_dy, q1_vx, q1_vy} = q1_side;

    // stage d: ramp numerator; far means the ramp would reach max speed
    logic                     d_valid_reg;
    logic [2*DATA_W-1:0]      d_prod_reg;
    logic                     d_far_reg, d_zero_reg;
    logic [DATA_W-1:0]        d_dist_reg;
    logic signed [DATA_W-1:0] d_dx_reg, d_dy_reg, d_vx_reg, d_vy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d_valid_reg <= q1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_prod_reg <= (2*DATA_W)'(ms_reg) * (2*DATA_W)'(q1_dist);
            d_far_reg  <= q1_dist >= {1'b0, slow_reg};
            d_zero_reg <= q1_dist == '0;
            d_dist_reg <= q1_dist;
            d_dx_reg   <= q1_dx;
            d_dy_reg   <= q1_dy;
            d_vx_reg   <= q1_vx;
            d_vy_reg   <= q1_vy;
        end
    end

    // ramp = max_speed * dist / slow_distance, only needed below slow_distance
    localparam int SIDE2_W = 5*DATA_W + 2;
    logic                     q2_valid;
    logic [DATA_W-1:0]        q2_ramp;
    logic [SIDE2_W-1:0]       q2_side;
    logic signed [DATA_W-1:0] q2_dx, q2_dy, q2_vx, q2_vy;
    logic [DATA_W-1:0]        q2_dist;
    logic                     q2_far, q2_zero;

    asv_div #(.DW(DATA_W), .SW(SIDE2_W)) u_ramp_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (d_valid_reg),
        .dividend (d_prod_reg),
        .divisor  ({1'b0, slow_reg}),
        .side_in  ({d_dx_reg, d_dy_reg, d_vx_reg, d_vy_reg, d_dist_reg, d_far_reg, d_zero_reg}),
        .out_valid(q2_valid),
        .quotient (q2_ramp),
        .side_out (q2_side)
    );
    assign {q2_dx, q2_dy, q2_vx, q2_vy, q2_dist, q2_far, q2_zero} = q2_side;

    // stage e: clipped speed
    logic                     e_valid_reg;
    logic [DATA_W-2:0]        e_speed_reg;
    logic [DATA_W-1:0]        e_dist_reg;
    logic                     e_zero_reg;
    logic signed [DATA_W-1:0] e_dx_reg, e_dy_reg, e_vx_reg, e_vy_reg;

    // stage f: speed times offset magnitude
    logic                     f_valid_reg;
    logic [2*DATA_W-1:0]      f_px_reg, f_py_reg;
    logic [DATA_W-1:0]        f_dist_reg;
    logic                     f_zero_reg, f_sgnx_reg, f_sgny_reg;
    logic signed [DATA_W-1:0] f_vx_reg, f_vy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            e_valid_reg <= q2_valid;
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_speed_reg <= q2_far ? ms_reg : q2_ramp[DATA_W-2:0];
            e_dist_reg  <= q2_dist;
            e_zero_reg  <= q2_zero;
            e_dx_reg    <= q2_dx;
            e_dy_reg    <= q2_dy;
            e_vx_reg    <= q2_vx;
            e_vy_reg    <= q2_vy;
            f_px_reg    <= (2*DATA_W)'(e_speed_reg) * (2*DATA_W)'(abs32(e_dx_reg));
            f_py_reg    <= (2*DATA_W)'(e_speed_reg) * (2*DATA_W)'(abs32(e_dy_reg));
            f_dist_reg  <= e_dist_reg;
            f_zero_reg  <= e_zero_reg;
            f_sgnx_reg  <= e_dx_reg[DATA_W-1];
            f_sgny_reg  <= e_dy_reg[DATA_W-1];
            f_vx_reg    <= e_vx_reg;
            f_vy_reg    <= e_vy_reg;
        end
    end

    // desired velocity magnitudes, bounded by speed
    localparam int SIDE3X_W = DATA_W + 2;
    localparam int SIDE3Y_W = DATA_W + 1;
    logic                     q3x_valid, q3y_valid;
    logic [DATA_W-1:0]        q3x_q, q3y_q;
    logic [SIDE3X_W-1:0]      q3x_side;
    logic [SIDE3Y_W-1:0]      q3y_side;
    logic signed [DATA_W-1:0] q3_vx, q3_vy;
    logic                     q3_sgnx, q3_sgny, q3_zero;

    asv_div #(.DW(DATA_W), .SW(SIDE3X_W)) u_desx_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (f_valid_reg),
        .dividend (f_px_reg),
        .divisor  (f_dist_reg),
        .side_in  ({f_vx_reg, f_sgnx_reg, f_zero_reg}),
        .out_valid(q3x_valid),
        .quotient (q3x_q),
        .side_out (q3x_side)
    );

    asv_div #(.DW(DATA_W), .SW(SIDE3Y_W)) u_desy_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (f_valid_reg),
        .dividend (f_py_reg),
        .divisor  (f_dist_reg),
        .side_in  ({f_vy_reg, f_sgny_reg}),
        .out_valid(q3y_valid),
        .quotient (q3y_q),
        .side_out (q3y_side)
    );
    assign {q3_vx, q3_sgnx, q3_zero} = q3x_side;
    assign {q3_vy, q3_sgny}          = q3y_side;

    // stage g: steering difference, saturated
    logic signed [DATA_W+1:0] g_desx, g_desy;
    assign g_desx = q3_sgnx ? -(DATA_W+2)'(q3x_q) : (DATA_W+2)'(q3x_q);
    assign g_desy = q3_sgny ? -(DATA_W+2)'(q3y_q) : (DATA_W+2)'(q3y_q);

    logic                     g_valid_reg;
    logic signed [DATA_W-1:0] g_sx_reg, g_sy_reg;
    logic                     g_zero_reg;

    // stage h: squares of the difference; zero covers both special cases
    logic                     h_valid_reg;
    logic [2*DATA_W-1:0]      h_sqx_reg, h_sqy_reg;
    logic [DATA_W-1:0]        h_ax_reg, h_ay_reg;
    logic                     h_sgnx_reg, h_sgny_reg, h_zero_reg;

    // stage i: sum
    logic                     i_valid_reg;
    logic [2*DATA_W-1:0]      i_sum_reg;
    logic [DATA_W-1:0]        i_ax_reg, i_ay_reg;
    logic                     i_sgnx_reg, i_sgny_reg, i_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
            i_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            g_valid_reg <= q3x_valid & q3y_valid;
            h_valid_reg <= g_valid_reg;
            i_valid_reg <= h_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_sx_reg   <= sat32(g_desx - (DATA_W+2)'(q3_vx));
            g_sy_reg   <= sat32(g_desy - (DATA_W+2)'(q3_vy));
            g_zero_reg <= q3_zero;
            h_sqx_reg  <= (2*DATA_W)'(abs32(g_sx_reg)) * (2*DATA_W)'(abs32(g_sx_reg));
            h_sqy_reg  <= (2*DATA_W)'(abs32(g_sy_reg)) * (2*DATA_W)'(abs32(g_sy_reg));
            h_ax_reg   <= abs32(g_sx_reg);
            h_ay_reg   <= abs32(g_sy_reg);
            h_sgnx_reg <= g_sx_reg[DATA_W-1];
            h_sgny_reg <= g_sy_reg[DATA_W-1];
            h_zero_reg <= g_zero_reg || (g_sx_reg == '0 && g_sy_reg == '0);
            i_sum_reg  <= h_sqx_reg + h_sqy_reg;
            i_ax_reg   <= h_ax_reg;
            i_ay_reg   <= h_ay_reg;
            i_sgnx_reg <= h_sgnx_reg;
            i_sgny_reg <= h_sgny_reg;
            i_zero_reg <= h_zero_reg;
        end
    end

    // length of the steering difference
    localparam int SIDE4_W = 2*DATA_W + 3;
    logic                q4_valid;
    logic [DATA_W-1:0]   q4_len;
    logic [SIDE4_W-1:0]  q4_side;
    logic [DATA_W-1:0]   q4_ax, q4_ay;
    logic                q4_sgnx, q4_sgny, q4_zero;

    asv_isqrt #(.OW(DATA_W), .SW(SIDE4_W)) u_len_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (i_valid_reg),
        .rad      (i_sum_reg),
        .side_in  ({i_ax_reg, i_ay_reg, i_sgnx_reg, i_sgny_reg, i_zero_reg}),
        .out_valid(q4_valid),
        .root     (q4_len),
        .side_out (q4_side)
    );
    assign {q4_ax, q4_ay, q4_sgnx, q4_sgny, q4_zero} = q4_side;

    // stage j: scale numerators by max speed
    logic                j_valid_reg;
    logic [2*DATA_W-1:0] j_px_reg, j_py_reg;
    logic [DATA_W-1:0]   j_len_reg;
    logic                j_sgnx_reg, j_sgny_reg, j_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            j_valid_reg <= q4_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            j_px_reg   <= (2*DATA_W)'(ms_reg) * (2*DATA_W)'(q4_ax);
            j_py_reg   <= (2*DATA_W)'(ms_reg) * (2*DATA_W)'(q4_ay);
            j_len_reg  <= q4_len;
            j_sgnx_reg <= q4_sgnx;
            j_sgny_reg <= q4_sgny;
            j_zero_reg <= q4_zero;
        end
    end

    // steering magnitudes, bounded by max speed
    logic              q5x_valid, q5y_valid;
    logic [DATA_W-1:0] q5x_q, q5y_q;
    logic [1:0]        q5x_side;
    logic              q5y_side;
    logic              q5_sgnx, q5_zero;

    asv_div #(.DW(DATA_W), .SW(2)) u_steerx_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (j_valid_reg),
        .dividend (j_px_reg),
        .divisor  (j_len_reg),
        .side_in  ({j_sgnx_reg, j_zero_reg}),
        .out_valid(q5x_valid),
        .quotient (q5x_q),
        .side_out (q5x_side)
    );

    asv_div #(.DW(DATA_W), .SW(1)) u_steery_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (j_valid_reg),
        .dividend (j_py_reg),
        .divisor  (j_len_reg),
        .side_in  (j_sgny_reg),
        .out_valid(q5y_valid),
        .quotient (q5y_q),
        .side_out (q5y_side)
    );
    assign {q5_sgnx, q5_zero} = q5x_side;

    // output register: sign, zero override
    logic signed [DATA_W-1:0] steer_x_reg, steer_y_reg;
    logic signed [DATA_W-1:0] steer_x_next, steer_y_next;

    always_comb
    begin
        if (q5_zero)
        begin
            steer_x_next = '0;
            steer_y_next = '0;
        end
        else
        begin
            steer_x_next = q5_sgnx ? -q5x_q : q5x_q;
            steer_y_next = q5y_side ? -q5y_q : q5y_q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= q5x_valid & q5y_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            steer_x_reg <= steer_x_next;
            steer_y_reg <= steer_y_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign steer_x   = steer_x_reg;
    assign steer_y   = steer_y_reg;

endmodule
